### hw/rtl/fpda_pkg.sv
// fpda_pkg: shared types and constants for the decimal ASCII printer.
// ASCII codes, printer state encoding and the BCD unit request struct.
// No dependencies.
`default_nettype none

package fpda_pkg;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_POINT = 8'h2E;
	localparam logic [7:0] ASCII_NINE  = 8'h39;

	localparam logic [3:0] MAX_DECIMALS = 4'd9;
	localparam int         VALUE_W      = 48;
	localparam int         UINT_W       = 32;
	localparam int         BCD_CAP      = 19;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CONV  = 7'b0000010,
		ST_STRIP = 7'b0000100,
		ST_SIGN  = 7'b0001000,
		ST_INT   = 7'b0010000,
		ST_POINT = 7'b0100000,
		ST_FRAC  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic bit_in;
		logic last_bit;
		logic shift_digit;
	} bcd_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/fpda_bcd.sv
// fpda_bcd: bit-serial binary to BCD converter (shift and add three).
// Saturates to all nines on overflow, then shifts digits out from the top.
// Depends on fpda_pkg.
`default_nettype none

module fpda_bcd
	import fpda_pkg::*;
#(
	parameter int DIGITS = 10
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire bcd_cmd_t cmd,
	output logic [3:0]    top_digit
);

	localparam int W = DIGITS * 4;

	logic [W-1:0] bcd_q;
	logic [W-1:0] adj;
	logic         ovf_q;
	logic         carry;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign carry     = adj[W-1];
	assign top_digit = bcd_q[W-1 -: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			ovf_q <= 1'b0;
		end else if (cmd.step) begin
			ovf_q <= ovf_q | carry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			bcd_q <= '0;
		end else if (cmd.step) begin
			if (cmd.last_bit && (ovf_q || carry)) begin
				bcd_q <= {DIGITS{4'h9}};
			end else begin
				bcd_q <= {adj[W-2:0], cmd.bit_in};
			end
		end else if (cmd.shift_digit) begin
			bcd_q <= bcd_q << 4;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/fpda_frac.sv
// fpda_frac: fraction digit unit, one decimal digit per step by times ten.
// Digit is the carry out of the fraction bits; remainder kept for next step.
// Depends on fpda_pkg.
`default_nettype none

module fpda_frac
	import fpda_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     load,
	input  wire logic [FRACTION_BITS-1:0] frac_in,
	input  wire logic                     step,
	output logic [3:0]                    digit
);

	logic [FRACTION_BITS-1:0] frac_q;
	logic [FRACTION_BITS+3:0] prod;

	assign prod  = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1);
	assign digit = prod[FRACTION_BITS+3:FRACTION_BITS];

	always_ff @(posedge clk) begin
		if (load) begin
			frac_q <= frac_in;
		end else if (step) begin
			frac_q <= prod[FRACTION_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/fixed_point_to_decimal_ascii_unit.sv
// Top level of the decimal ASCII printer: control sequencer and output register.
// Depends on fpda_pkg, fpda_bcd, fpda_frac.
//
// A request is taken when start is high and busy is low. The integer part is
// converted one bit per cycle in a shift-and-add-three BCD register, from a
// source of max(32, 48 - FRACTION_BITS) bits (32 by default); leading zero
// digits are then dropped one per cycle, and the characters follow one per
// cycle with strobe high for exactly one cycle each; last marks the final
// character. The receiver cannot stall; busy drops in the cycle that shows
// the final character, so the next request may follow.
`default_nettype none

module fixed_point_to_decimal_ascii_unit
	import fpda_pkg::*;
#(
	parameter int FRACTION_BITS  = 16,
	parameter int MAX_INT_DIGITS = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      kind,
	input  wire logic signed [VALUE_W-1:0] value,
	input  wire logic [3:0]                decimals,
	output logic                           strobe,
	output logic [7:0]                     character,
	output logic                           last
);

	localparam int INT_W      = VALUE_W - FRACTION_BITS;
	localparam int SRC_W      = (INT_W > UINT_W) ? INT_W : UINT_W;
	localparam int INT_DIGITS = (MAX_INT_DIGITS > BCD_CAP) ? BCD_CAP : MAX_INT_DIGITS;
	localparam int BCNT_W     = $clog2(SRC_W + 1);
	localparam int DCNT_W     = $clog2(INT_DIGITS + 1);

	state_t              state_q;
	logic [SRC_W-1:0]    src_q;
	logic [BCNT_W-1:0]   bcnt_q;
	logic [DCNT_W-1:0]   dcnt_q;
	logic [3:0]          dec_q;
	logic                neg_q;
	logic                kind_q;
	logic                strobe_q;
	logic [7:0]          char_q;
	logic                last_q;

	logic                accept;
	logic [VALUE_W-1:0]  mag;
	logic [3:0]          top_digit;
	logic [3:0]          frac_digit;
	logic                bcnt_one;
	logic                dcnt_one;
	logic                strip_more;
	bcd_cmd_t            bcd_cmd;

	assign accept     = start && (state_q == ST_IDLE);
	assign mag        = value[VALUE_W-1] ? (~value + 1'b1) : value;
	assign bcnt_one   = (bcnt_q == BCNT_W'(1));
	assign dcnt_one   = (dcnt_q == DCNT_W'(1));
	assign strip_more = (top_digit == 4'd0) && !dcnt_one;

	always_comb begin
		bcd_cmd             = '0;
		bcd_cmd.clear       = accept;
		bcd_cmd.step        = (state_q == ST_CONV);
		bcd_cmd.bit_in      = src_q[SRC_W-1];
		bcd_cmd.last_bit    = bcnt_one;
		bcd_cmd.shift_digit = ((state_q == ST_STRIP) && strip_more) || (state_q == ST_INT);
	end

	fpda_bcd #(
		.DIGITS(INT_DIGITS)
	) u_bcd (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (bcd_cmd),
		.top_digit(top_digit)
	);

	fpda_frac #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_frac (
		.clk    (clk),
		.load   (accept),
		.frac_in(mag[FRACTION_BITS-1:0]),
		.step   (state_q == ST_FRAC),
		.digit  (frac_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			bcnt_q   <= '0;
			dcnt_q   <= '0;
			dec_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						bcnt_q  <= BCNT_W'(SRC_W);
						dec_q   <= (decimals > MAX_DECIMALS) ? MAX_DECIMALS : decimals;
					end
				end
				ST_CONV: begin
					bcnt_q <= bcnt_q - 1'b1;
					if (bcnt_one) begin
						state_q <= ST_STRIP;
						dcnt_q  <= DCNT_W'(INT_DIGITS);
					end
				end
				ST_STRIP: begin
					if (strip_more) begin
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_INT;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_INT;
				end
				ST_INT: begin
					strobe_q <= 1'b1;
					dcnt_q   <= dcnt_q - 1'b1;
					if (dcnt_one) begin
						if (kind_q) begin
							state_q <= ST_POINT;
						end else begin
							last_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_POINT: begin
					strobe_q <= 1'b1;
					if (dec_q == 4'd0) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_FRAC;
					end
				end
				ST_FRAC: begin
					strobe_q <= 1'b1;
					dec_q    <= dec_q - 1'b1;
					if (dec_q == 4'd1) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			neg_q  <= kind && value[VALUE_W-1];
			if (kind) begin
				src_q <= SRC_W'(mag[VALUE_W-1:FRACTION_BITS]);
			end else begin
				src_q <= SRC_W'(value[UINT_W-1:0]);
			end
		end else if (state_q == ST_CONV) begin
			src_q <= src_q << 1;
		end
		case (state_q)
			ST_SIGN:  char_q <= ASCII_MINUS;
			ST_INT:   char_q <= ASCII_ZERO + {4'b0, top_digit};
			ST_POINT: char_q <= ASCII_POINT;
			ST_FRAC:  char_q <= ASCII_ZERO + {4'b0, frac_digit};
			default:  char_q <= char_q;
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> (state_q == ST_IDLE))
		else $error("last character shown while sequencer still running");

	a_quiet_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !strobe_q)
		else $error("strobe during integer conversion");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_CONV))
		else $error("request not taken into conversion");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> ((char_q >= ASCII_ZERO && char_q <= ASCII_NINE) ||
			char_q == ASCII_MINUS || char_q == ASCII_POINT))
		else $error("character outside digit, minus and point");

endmodule

`default_nettype wire

### tb/sv/fixed_point_to_decimal_ascii_unit_tb.sv
// Self-checking bench for the decimal ASCII printer: a queued request driver, a
// result monitor and a bit-true predictor of the character runs for both number kinds.
// Depends on fpda_pkg and fixed_point_to_decimal_ascii_unit.
module fixed_point_to_decimal_ascii_unit_tb;
	import fpda_pkg::*;

	localparam int FRAC_BITS   = 16;
	localparam int INT_DIGITS  = 10;
	localparam int RANDOM_REQS = 210;
	localparam int TAIL_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic              drain;
		logic              kind;
		logic [VALUE_W-1:0] value;
		logic [3:0]        decimals;
	} number_req_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} ascii_char_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      kind = 1'b0;
	logic signed [VALUE_W-1:0] value = '0;
	logic [3:0]                decimals = 4'd0;
	wire                       busy;
	wire                       strobe;
	wire [7:0]                 character;
	wire                       last;

	number_req_t pending_reqs[$];
	ascii_char_t expected_chars[$];
	number_req_t next_req;
	logic        req_taken = 1'b0;
	int          reqs_sent = 0;
	int          uint_reqs = 0;
	int          fixed_reqs = 0;
	int          chars_checked = 0;
	int          errors = 0;
	int          cycles = 0;

	fixed_point_to_decimal_ascii_unit #(
		.FRACTION_BITS (FRAC_BITS),
		.MAX_INT_DIGITS(INT_DIGITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.value    (value),
		.decimals (decimals),
		.strobe   (strobe),
		.character(character),
		.last     (last)
	);

	always #4 clk = ~clk;

	// expected character run for one accepted request
	task automatic predict_ascii_run(input logic k, input logic [VALUE_W-1:0] v,
			input logic [3:0] d);
		logic [7:0]         line[0:31];
		logic [7:0]         digs[0:19];
		logic [VALUE_W-1:0] mag;
		logic [63:0]        n;
		logic [63:0]        lim;
		logic [63:0]        frac;
		logic [63:0]        fmask;
		logic [3:0]         dcount;
		int                 cnt;
		int                 nd;
		int                 i;
		cnt = 0;
		nd = 0;
		mag = v;
		if (k) begin
			if (v[VALUE_W-1]) begin
				mag = ~v + 1'b1;
				line[cnt] = ASCII_MINUS;
				cnt++;
			end
			n = 64'(mag >> FRAC_BITS);
		end else begin
			n = 64'(v[UINT_W-1:0]);
		end
		lim = 64'd1;
		for (i = 0; i < INT_DIGITS && lim <= 64'hFFFF_FFFF_FFFF_FFFF / 10; i++)
			lim = lim * 10;
		lim = lim - 1;
		if (n > lim)
			n = lim;
		if (n == 0) begin
			digs[0] = 8'd0;
			nd = 1;
		end
		while (n != 0) begin
			digs[nd] = 8'(n % 10);
			n = n / 10;
			nd++;
		end
		for (i = nd - 1; i >= 0; i--) begin
			line[cnt] = ASCII_ZERO + digs[i];
			cnt++;
		end
		if (k) begin
			line[cnt] = ASCII_POINT;
			cnt++;
			dcount = (d > MAX_DECIMALS) ? MAX_DECIMALS : d;
			fmask = (64'd1 << FRAC_BITS) - 1;
			frac = 64'(mag) & fmask;
			for (i = 0; i < dcount; i++) begin
				frac = frac * 10;
				line[cnt] = ASCII_ZERO + 8'(frac >> FRAC_BITS);
				cnt++;
				frac = frac & fmask;
			end
		end
		for (i = 0; i < cnt; i++)
			expected_chars.push_back('{ch: line[i], last: (i == cnt - 1)});
	endtask

	task automatic queue_number(input logic k, input logic [VALUE_W-1:0] v,
			input logic [3:0] d);
		pending_reqs.push_back('{drain: 1'b0, kind: k, value: v, decimals: d});
	endtask

	task automatic queue_drain();
		pending_reqs.push_back('{drain: 1'b1, kind: 1'b0, value: '0, decimals: 4'd0});
	endtask

	// monitor: check characters, then predict for a request taken at this edge
	always @(posedge clk) begin
		if (strobe) begin
			if (expected_chars.size() == 0) begin
				if (errors < 10)
					$display("unexpected character %h last %b", character, last);
				errors++;
			end else begin
				if (character !== expected_chars[0].ch || last !== expected_chars[0].last) begin
					if (errors < 10)
						$display("mismatch: expected char %h last %b, got char %h last %b",
							expected_chars[0].ch, expected_chars[0].last, character, last);
					errors++;
				end
				expected_chars.pop_front();
				chars_checked++;
			end
		end
		if (arst_n && start && !busy) begin
			predict_ascii_run(kind, value, decimals);
			if (kind)
				fixed_reqs++;
			else
				uint_reqs++;
		end
		req_taken <= arst_n && start && !busy;
	end

	// driver: hold a request until taken, honor drain markers, idle at random except while reqs_sent is 80 to 149
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !req_taken) begin
		end else if (pending_reqs.size() != 0 && pending_reqs[0].drain) begin
			start <= 1'b0;
			if (expected_chars.size() == 0 && !busy)
				pending_reqs.delete(0);
		end else if (pending_reqs.size() != 0 &&
				((reqs_sent >= 80 && reqs_sent < 150) || $urandom_range(99) >= 17)) begin
			next_req = pending_reqs.pop_front();
			start <= 1'b1;
			kind <= next_req.kind;
			value <= next_req.value;
			decimals <= next_req.decimals;
			reqs_sent++;
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL fixed_point_to_decimal_ascii_unit");
			$finish;
		end
	end

	initial begin
		logic [63:0]        r;
		logic [VALUE_W-1:0] v;
		int                 sel;
		int                 i;
		// directed: field extremes and special cases
		queue_number(1'b0, 48'd0, 4'd0);
		queue_number(1'b0, 48'd9, 4'd15);
		queue_number(1'b0, 48'd10, 4'd3);
		queue_number(1'b0, 48'h0000_FFFF_FFFF, 4'd0);
		queue_number(1'b0, 48'hFFFF_0000_0007, 4'd9);
		queue_number(1'b0, 48'd1000000000, 4'd0);
		queue_number(1'b1, 48'd0, 4'd0);
		queue_number(1'b1, 48'd0, 4'd9);
		queue_number(1'b1, 48'd1, 4'd9);
		queue_number(1'b1, 48'hFFFF_FFFF_FFFF, 4'd9);
		queue_number(1'b1, 48'hFFFF_FFFF_FFFF, 4'd0);
		queue_number(1'b1, 48'h7FFF_FFFF_FFFF, 4'd9);
		queue_number(1'b1, 48'h8000_0000_0000, 4'd9);
		queue_number(1'b1, 48'h0000_0003_8000, 4'd15);
		queue_number(1'b1, 48'h0000_0003_8000, 4'd10);
		queue_number(1'b1, 48'h0000_000C_8000, 4'd3);
		queue_number(1'b1, -48'sh0000_000C_C000, 4'd2);
		queue_number(1'b1, 48'h0000_0001_0000, 4'd1);
		queue_number(1'b1, -48'sh0000_0000_8000, 4'd4);
		queue_number(1'b1, 48'h0000_FFFF_FFFF, 4'd5);
		queue_drain();
		for (i = 0; i < RANDOM_REQS; i++) begin
			r = {$urandom(), $urandom()};
			sel = $urandom_range(9);
			if (sel <= 2) begin
				queue_number(1'b1, r[VALUE_W-1:0], 4'($urandom_range(15)));
			end else if (sel <= 5) begin
				v = {16'd0, 16'($urandom_range(999)), r[15:0]};
				if (r[40])
					v = -v;
				queue_number(1'b1, v, 4'($urandom_range(9)));
			end else if (sel == 6) begin
				v = -{32'd0, r[15:0]};
				queue_number(1'b1, v, 4'($urandom_range(3)));
			end else if (sel == 7) begin
				queue_number(1'b0, {r[47:32], 32'($urandom_range(99999))}, r[35:32]);
			end else begin
				queue_number(1'b0, r[VALUE_W-1:0], r[35:32]);
			end
			if (i == RANDOM_REQS / 2)
				queue_drain();
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() != 0 || start)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d unsigned and %0d fixed-point numbers, %0d characters checked",
			uint_reqs, fixed_reqs, chars_checked);
		$display("%0d mismatches or stray characters", errors);
		if (errors == 0)
			$display("PASS fixed_point_to_decimal_ascii_unit");
		else
			$display("FAIL fixed_point_to_decimal_ascii_unit");
		$finish;
	end

endmodule
